@@ rtl/fsd_pkg.sv @@
// Shared constants and types for the FM sample to clock divisor block.
package fsd_pkg;

   localparam int unsigned DIVISOR_BITS_DEF = 24;

   localparam int unsigned SAMPLE_W    = 16;
   localparam int unsigned CARRIER_W   = 28;
   localparam int unsigned DEVIATION_W = 20;
   localparam int unsigned CSR_DATA_W  = 28;
   localparam int unsigned CSR_INDEX_W = 1;

   // sample (signed 16) times deviation (unsigned 20, one sign bit added)
   localparam int unsigned PROD_W     = SAMPLE_W + DEVIATION_W + 1;
   localparam int unsigned FRAC_SHIFT = 15;
   localparam int unsigned OFFSET_W   = PROD_W - FRAC_SHIFT;

   // signed frequency and its positive magnitude
   localparam int unsigned FREQ_W = 30;
   localparam int unsigned MAG_W  = FREQ_W - 1;

   // 500 MHz source times 4096 for the 12.12 divisor
   localparam int unsigned           DIVIDEND_W = 41;
   localparam logic [DIVIDEND_W-1:0] DIVIDEND   = 41'd2048000000000;

   localparam logic [CARRIER_W-1:0]   CARRIER_RESET   = 28'd100000000;
   localparam logic [DEVIATION_W-1:0] DEVIATION_RESET = 20'd75000;

   localparam logic [CSR_INDEX_W-1:0] CSR_CARRIER   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVIATION = 1'b1;

   localparam int unsigned JOB_DEPTH = 4;
   localparam int unsigned RSP_DEPTH = 2;

   // one classified sample on its way from front to back
   typedef struct packed {
      logic [MAG_W-1:0] freq;
      logic             sat;
   } fsd_job_type;

endpackage

@@ rtl/fsd_fifo.sv @@
// Small register-based queue with occupancy count.
module fsd_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ rtl/fsd_front.sv @@
// Front end: config registers, deviation multiply, frequency and range classification.
module fsd_front #(
   parameter int unsigned DIVISOR_BITS = fsd_pkg::DIVISOR_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [fsd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [fsd_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                 push,
   output logic                                 full,
   input  logic signed [fsd_pkg::SAMPLE_W-1:0]  sample,
   output logic                                 job_push,
   output fsd_pkg::fsd_job_type                 job,
   input  logic                                 job_full
);

   import fsd_pkg::*;

   // dividend above the quotient bits; a frequency at or below it overflows
   localparam logic [MAG_W-1:0] TOP = MAG_W'(DIVIDEND >> DIVISOR_BITS);

   logic [CARRIER_W-1:0]     carrier_ff, carrier_in;
   logic [DEVIATION_W-1:0]   deviation_ff, deviation_in;
   logic                     a_valid_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     b_valid_ff;
   fsd_job_type              job_ff, job_in;

   logic                       advance;
   logic signed [DEVIATION_W:0] dev_s;
   logic signed [OFFSET_W-1:0] offset;
   logic signed [FREQ_W-1:0]   freq;
   logic [MAG_W-1:0]           mag;
   logic                       nonpos;

   // stall both stages together when stage b holds a job and the job queue is full
   assign advance  = !b_valid_ff || !job_full;
   assign full     = !advance;
   assign job_push = b_valid_ff && !job_full;
   assign job      = job_ff;

   always_comb begin
      carrier_in   = carrier_ff;
      deviation_in = deviation_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CARRIER:   carrier_in   = csr_wdata[CARRIER_W-1:0];
            CSR_DEVIATION: deviation_in = csr_wdata[DEVIATION_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      dev_s   = $signed({1'b0, deviation_ff});
      prod_in = sample * dev_s;
   end

   // floor by 2^15, add carrier, classify
   always_comb begin
      offset      = OFFSET_W'(prod_ff >>> FRAC_SHIFT);
      freq        = $signed(FREQ_W'({1'b0, carrier_ff})) + FREQ_W'(offset);
      mag         = freq[MAG_W-1:0];
      nonpos      = freq[FREQ_W-1] || (freq == '0);
      job_in.freq = mag;
      job_in.sat  = nonpos || (mag <= TOP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carrier_ff   <= CARRIER_RESET;
         deviation_ff <= DEVIATION_RESET;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
      end else begin
         carrier_ff   <= carrier_in;
         deviation_ff <= deviation_in;
         if (advance) begin
            a_valid_ff <= push;
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         job_ff  <= job_in;
      end
   end

endmodule

@@ rtl/fsd_back.sv @@
// Back end: pipelined restoring divider, one quotient bit per stage, with saturation.
module fsd_back #(
   parameter int unsigned DIVISOR_BITS = fsd_pkg::DIVISOR_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    job_valid,
   input  fsd_pkg::fsd_job_type    job,
   output logic                    job_pop,
   output logic                    res_push,
   output logic [DIVISOR_BITS-1:0] res_divisor,
   output logic                    res_sat,
   input  logic                    res_full
);

   import fsd_pkg::*;

   localparam logic [MAG_W-1:0] TOP = MAG_W'(DIVIDEND >> DIVISOR_BITS);

   logic                    valid_ff [DIVISOR_BITS];
   logic [MAG_W-1:0]        freq_ff  [DIVISOR_BITS];
   logic [MAG_W-1:0]        rem_ff   [DIVISOR_BITS];
   logic [DIVISOR_BITS-1:0] quo_ff   [DIVISOR_BITS];
   logic                    sat_ff   [DIVISOR_BITS];

   logic                    src_valid [DIVISOR_BITS];
   logic [MAG_W-1:0]        src_freq  [DIVISOR_BITS];
   logic [MAG_W-1:0]        src_rem   [DIVISOR_BITS];
   logic [DIVISOR_BITS-1:0] src_quo   [DIVISOR_BITS];
   logic                    src_sat   [DIVISOR_BITS];

   logic advance;

   // advance the whole pipe unless the last stage is blocked
   assign advance = !valid_ff[DIVISOR_BITS-1] || !res_full;
   assign job_pop = advance && job_valid;

   assign src_valid[0] = job_valid;
   assign src_freq[0]  = job.freq;
   assign src_rem[0]   = TOP;
   assign src_quo[0]   = '0;
   assign src_sat[0]   = job.sat;

   for (genvar k = 1; k < DIVISOR_BITS; k++) begin : g_link
      assign src_valid[k] = valid_ff[k-1];
      assign src_freq[k]  = freq_ff[k-1];
      assign src_rem[k]   = rem_ff[k-1];
      assign src_quo[k]   = quo_ff[k-1];
      assign src_sat[k]   = sat_ff[k-1];
   end

   for (genvar k = 0; k < DIVISOR_BITS; k++) begin : g_stage
      logic [MAG_W:0]          trial;
      logic                    fits;
      logic [MAG_W-1:0]        rem_in;
      logic [DIVISOR_BITS-1:0] quo_in;

      // bring down the next dividend bit, subtract where it fits
      always_comb begin
         trial  = {src_rem[k], DIVIDEND[DIVISOR_BITS-1-k]};
         fits   = (trial >= {1'b0, src_freq[k]});
         rem_in = fits ? MAG_W'(trial - {1'b0, src_freq[k]}) : trial[MAG_W-1:0];
         quo_in = {src_quo[k][DIVISOR_BITS-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= src_valid[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            freq_ff[k] <= src_freq[k];
            rem_ff[k]  <= rem_in;
            quo_ff[k]  <= quo_in;
            sat_ff[k]  <= src_sat[k];
         end
      end
   end

   assign res_push    = advance && valid_ff[DIVISOR_BITS-1];
   assign res_sat     = sat_ff[DIVISOR_BITS-1];
   assign res_divisor = sat_ff[DIVISOR_BITS-1] ? '1 : quo_ff[DIVISOR_BITS-1];

endmodule

@@ rtl/fm_sample_to_clock_divisor.sv @@
// Top level of the FM sample to fractional clock divisor block.
//
// Usage:
//   Each input beat is one signed 16-bit PCM sample, pushed with push while
//   full is low. The block forms the FM frequency carrier_hz +
//   floor(sample * deviation_hz / 2^15) and returns the 12.12 divisor
//   floor(2048000000000 / freq) for a 500 MHz source on the result queue:
//   a result beat is presented while empty is low and taken with pop.
//   A nonpositive frequency or a quotient wider than DIVISOR_BITS gives an
//   all-ones divisor with out_of_range set.
//   The user writes carrier_hz (index 0) and deviation_hz (index 1) via the
//   csr_ port only while no sample is in flight; not enforced by the block.
// Throughput and pipeline:
//   One sample per cycle while full stays low. A sample passes through two
//   front stages (multiply, then add and classify), the job queue, one
//   divider stage per quotient bit, and the result queue.
// Reset and stalls:
//   Reset loads the carrier and deviation defaults and empties both queues
//   and the pipelines. When pop stays low the result queue fills, the
//   divider pipe holds, then the job queue fills and full rises.
module fm_sample_to_clock_divisor #(
   parameter int unsigned DIVISOR_BITS = fsd_pkg::DIVISOR_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_we,
   input  logic [fsd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fsd_pkg::CSR_DATA_W-1:0]      csr_wdata,
   // sample channel
   input  logic                                push,
   output logic                                full,
   input  logic signed [fsd_pkg::SAMPLE_W-1:0] req_pcm_sample,
   // result channel
   output logic                                empty,
   input  logic                                pop,
   output logic [DIVISOR_BITS-1:0]             rsp_clock_divisor,
   output logic                                rsp_out_of_range
);

   import fsd_pkg::*;

   localparam int unsigned JOB_W = $bits(fsd_job_type);
   localparam int unsigned RSP_W = DIVISOR_BITS + 1;

   logic                    job_push, job_full, job_pop, job_empty;
   fsd_job_type             job_tail, job_head;
   logic [JOB_W-1:0]        job_rd;

   logic                    res_push, res_full, res_sat;
   logic [DIVISOR_BITS-1:0] res_divisor;
   logic [RSP_W-1:0]        rsp_rd;

   // accept and classify samples
   fsd_front #(
      .DIVISOR_BITS (DIVISOR_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .push      (push),
      .full      (full),
      .sample    (req_pcm_sample),
      .job_push  (job_push),
      .job       (job_tail),
      .job_full  (job_full)
   );

   // decouple front and divider
   fsd_fifo #(
      .WIDTH (JOB_W),
      .DEPTH (JOB_DEPTH)
   ) u_job_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (job_push),
      .wr_data (job_tail),
      .full    (job_full),
      .pop     (job_pop),
      .rd_data (job_rd),
      .empty   (job_empty)
   );

   assign job_head = fsd_job_type'(job_rd);

   // divide and saturate
   fsd_back #(
      .DIVISOR_BITS (DIVISOR_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (!job_empty),
      .job         (job_head),
      .job_pop     (job_pop),
      .res_push    (res_push),
      .res_divisor (res_divisor),
      .res_sat     (res_sat),
      .res_full    (res_full)
   );

   // hold finished results until the receiver pops them
   fsd_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .wr_data ({res_divisor, res_sat}),
      .full    (res_full),
      .pop     (pop),
      .rd_data (rsp_rd),
      .empty   (empty)
   );

   assign rsp_clock_divisor = rsp_rd[RSP_W-1:1];
   assign rsp_out_of_range  = rsp_rd[0];

endmodule

@@ tb/fm_sample_to_clock_divisor_test.sv @@
// Testbench for the FM sample to clock divisor block: directed table, then random phases.
module fm_sample_to_clock_divisor_test;
   import fsd_pkg::*;

   localparam int unsigned DIVISOR_BITS = DIVISOR_BITS_DEF;
   // base of the wait after the last expected beat, used by settle and the final drain
   localparam int unsigned LATENCY      = DIVISOR_BITS + 3;
   localparam int unsigned LIMIT_CYCLES = 300000;
   localparam int unsigned PHASES       = 12;
   localparam int unsigned PHASE_ITEMS  = 80;
   localparam int unsigned HOLD_CYCLES  = 200;
   // phase in which the receiver holds off, and one in which the sender drains
   localparam int unsigned PRESSURE_PHASE = 9;
   localparam int unsigned PAUSE_PHASE    = 5;

   localparam logic [DIVISOR_BITS-1:0] DIVISOR_MAX = '1;
   // 500 MHz source clock scaled by 4096 for the 12.12 format
   localparam longint unsigned TICKS_12_12 = 64'd2048000000000;
   localparam int unsigned     SAMPLE_SCALE_LOG2 = 15;

   typedef struct packed {
      logic [DIVISOR_BITS-1:0] divisor;
      logic                    sat;
   } divisor_beat_type;

   typedef enum logic [1:0] {ROW_SAMPLE, ROW_CARRIER, ROW_DEVIATION} row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      logic [CSR_DATA_W-1:0]   value;    // sample in the low 16 bits, or register data
      logic                    known;    // expected beat typed in below
      logic [DIVISOR_BITS-1:0] divisor;
      logic                    sat;
   } directed_row_type;

   typedef enum int {
      CFG_DEFAULT, CFG_IN_RANGE, CFG_LOW_CARRIER, CFG_TOP, CFG_BOTTOM, CFG_RAW, CFG_KINDS
   } cfg_kind_type;

   localparam int unsigned DIRECTED_ROWS = 30;

   // Directed stimulus. Register rows are applied with the block idle.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // reset defaults: 100 MHz carrier divides the dividend exactly
      '{ROW_SAMPLE,    28'h0000000, 1'b1, 24'd20480,   1'b0},
      '{ROW_SAMPLE,    28'h0007FFF, 1'b0, 24'd0,       1'b0},
      '{ROW_SAMPLE,    28'h0008000, 1'b0, 24'd0,       1'b0},
      // minus one rounds down, not toward zero
      '{ROW_SAMPLE,    28'h000FFFF, 1'b0, 24'd0,       1'b0},
      '{ROW_SAMPLE,    28'h0000001, 1'b0, 24'd0,       1'b0},
      '{ROW_SAMPLE,    28'h0005555, 1'b0, 24'd0,       1'b0},
      '{ROW_SAMPLE,    28'h000AAAA, 1'b0, 24'd0,       1'b0},
      // top of the carrier range
      '{ROW_CARRIER,   28'd250000000, 1'b0, 24'd0,     1'b0},
      '{ROW_SAMPLE,    28'h0000000, 1'b1, 24'd8192,    1'b0},
      '{ROW_DEVIATION, 28'd1000000, 1'b0, 24'd0,       1'b0},
      '{ROW_SAMPLE,    28'h0007FFF, 1'b0, 24'd0,       1'b0},
      '{ROW_SAMPLE,    28'h0008000, 1'b0, 24'd0,       1'b0},
      // 1 Hz carrier: quotient far too wide, or frequency below zero
      '{ROW_CARRIER,   28'd1,       1'b0, 24'd0,       1'b0},
      '{ROW_SAMPLE,    28'h0000000, 1'b1, DIVISOR_MAX, 1'b1},
      '{ROW_SAMPLE,    28'h0008000, 1'b1, DIVISOR_MAX, 1'b1},
      '{ROW_SAMPLE,    28'h0007FFF, 1'b0, 24'd0,       1'b0},
      // zero carrier; deviation data with only upper bits set masks to zero
      '{ROW_CARRIER,   28'd0,       1'b0, 24'd0,       1'b0},
      '{ROW_DEVIATION, 28'hFF00000, 1'b0, 24'd0,       1'b0},
      '{ROW_SAMPLE,    28'h0000000, 1'b1, DIVISOR_MAX, 1'b1},
      '{ROW_SAMPLE,    28'h0008000, 1'b1, DIVISOR_MAX, 1'b1},
      // straddle the 24-bit saturation boundary at 122070 / 122071 Hz
      '{ROW_CARRIER,   28'd122071,  1'b0, 24'd0,       1'b0},
      '{ROW_DEVIATION, 28'd1,       1'b0, 24'd0,       1'b0},
      '{ROW_SAMPLE,    28'h0000000, 1'b0, 24'd0,       1'b0},
      '{ROW_SAMPLE,    28'h0008000, 1'b0, 24'd0,       1'b0},
      '{ROW_SAMPLE,    28'h0007FFF, 1'b0, 24'd0,       1'b0},
      // all-ones registers, beyond the stated ranges
      '{ROW_CARRIER,   28'hFFFFFFF, 1'b0, 24'd0,       1'b0},
      '{ROW_DEVIATION, 28'h00FFFFF, 1'b0, 24'd0,       1'b0},
      '{ROW_SAMPLE,    28'h0008000, 1'b0, 24'd0,       1'b0},
      '{ROW_SAMPLE,    28'h0007FFF, 1'b0, 24'd0,       1'b0},
      '{ROW_SAMPLE,    28'h0000000, 1'b0, 24'd0,       1'b0}
   };

   logic                          clock;
   logic                          reset     = 1'b1;
   logic                          csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0]        csr_index = CSR_CARRIER;
   logic [CSR_DATA_W-1:0]         csr_wdata = '0;
   logic                          push      = 1'b0;
   logic                          full;
   logic signed [SAMPLE_W-1:0]    req_pcm_sample = '0;
   logic                          empty;
   logic                          pop       = 1'b0;
   logic [DIVISOR_BITS-1:0]       rsp_clock_divisor;
   logic                          rsp_out_of_range;

   // shadow copies of the two registers, as the block should hold them
   logic [CARRIER_W-1:0]   carrier_shadow   = CARRIER_RESET;
   logic [DEVIATION_W-1:0] deviation_shadow = DEVIATION_RESET;

   divisor_beat_type expected_divisors [$];
   divisor_beat_type head_beat;

   int unsigned send_idle_pct = 19;
   int unsigned recv_idle_pct = 46;
   int unsigned hold_requests = 0;
   int unsigned hold_seen     = 0;
   int unsigned hold_left     = 0;
   int unsigned cycle_count   = 0;
   int unsigned errors        = 0;
   int unsigned samples_sent  = 0;
   int unsigned beats_checked = 0;
   int unsigned saturated_seen = 0;
   int unsigned reg_writes    = 0;

   fm_sample_to_clock_divisor #(
      .DIVISOR_BITS(DIVISOR_BITS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .push             (push),
      .full             (full),
      .req_pcm_sample   (req_pcm_sample),
      .empty            (empty),
      .pop              (pop),
      .rsp_clock_divisor(rsp_clock_divisor),
      .rsp_out_of_range (rsp_out_of_range)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Frequency = carrier + floor(sample * deviation / 2^15); the divisor is the
   // truncated quotient of the scaled source clock, saturated to all ones.
   function automatic divisor_beat_type predict_divisor(input logic signed [SAMPLE_W-1:0] pcm);
      longint           product;
      longint           freq;
      longint unsigned  quotient;
      divisor_beat_type beat;
      product = longint'(pcm) * longint'(deviation_shadow);
      // arithmetic shift of a signed value floors toward minus infinity
      freq = longint'(carrier_shadow) + (product >>> SAMPLE_SCALE_LOG2);
      beat.divisor = DIVISOR_MAX;
      beat.sat     = 1'b1;
      if (freq > 0) begin
         quotient = TICKS_12_12 / $unsigned(freq);
         if (quotient <= DIVISOR_MAX) begin
            beat.divisor = quotient[DIVISOR_BITS-1:0];
            beat.sat     = 1'b0;
         end
      end
      return beat;
   endfunction

   // Offer one sample beat, after a random idle gap; return at the edge that
   // takes it, with push still high so that a following beat can go back to back.
   task automatic offer_sample(input logic signed [SAMPLE_W-1:0] pcm,
                               input divisor_beat_type beat);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push           <= 1'b1;
      req_pcm_sample <= pcm;
      @(posedge clock);
      while (full) @(posedge clock);
      expected_divisors.push_back(beat);
      samples_sent++;
   endtask

   // Wait for every expected beat, then let the pipe run empty.
   task automatic settle();
      while (expected_divisors.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // One register write; csr_we drops again before the task returns, so writes never abut.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == CSR_CARRIER) carrier_shadow = data[CARRIER_W-1:0];
      else                      deviation_shadow = data[DEVIATION_W-1:0];
      reg_writes++;
      @(posedge clock);
   endtask

   // Receiver: check each popped beat against the oldest expectation, then
   // decide pop for the next edge. A hold request stalls it for a long stretch.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_divisors.size() == 0) begin
               errors++;
               $display("%0t: result beat with nothing expected: divisor %h flag %b",
                        $time, rsp_clock_divisor, rsp_out_of_range);
            end else begin
               head_beat = expected_divisors.pop_front();
               beats_checked++;
               if (rsp_clock_divisor !== head_beat.divisor) begin
                  errors++;
                  $display("%0t: clock_divisor expected %h actual %h",
                           $time, head_beat.divisor, rsp_clock_divisor);
               end
               if (rsp_out_of_range !== head_beat.sat) begin
                  errors++;
                  $display("%0t: out_of_range expected %b actual %b",
                           $time, head_beat.sat, rsp_out_of_range);
               end
               if (rsp_out_of_range === 1'b1) saturated_seen++;
            end
         end
         if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog: a stuck handshake or a missing beat ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: timeout with %0d beats still expected", $time,
                  expected_divisors.size());
         $display("[fm_sample_to_clock_divisor] ERROR");
         $finish;
      end
   end

   initial begin
      logic signed [SAMPLE_W-1:0] pcm;
      divisor_beat_type           beat;
      logic [CSR_DATA_W-1:0]      carrier_pick;
      logic [CSR_DATA_W-1:0]      deviation_pick;
      cfg_kind_type               cfg_kind;

      // Hold reset from the start, then release it at an edge.
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table. Drop push and drain before any register row.
      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            ROW_SAMPLE: begin
               pcm = directed_rows[i].value[SAMPLE_W-1:0];
               if (directed_rows[i].known) begin
                  beat.divisor = directed_rows[i].divisor;
                  beat.sat     = directed_rows[i].sat;
               end else begin
                  beat = predict_divisor(pcm);
               end
               offer_sample(pcm, beat);
            end
            ROW_CARRIER: begin
               push <= 1'b0;
               settle();
               write_reg(CSR_CARRIER, directed_rows[i].value);
            end
            default: begin
               push <= 1'b0;
               settle();
               write_reg(CSR_DEVIATION, directed_rows[i].value);
            end
         endcase
      end

      // Random phases: each one drains, picks a register setting, then streams
      // samples. Idling shifts from the receiver to the sender, then stops.
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase < 4) begin
            send_idle_pct = 19;
            recv_idle_pct = 46;
         end else if (phase < 8) begin
            send_idle_pct = 46;
            recv_idle_pct = 19;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         push <= 1'b0;
         settle();

         cfg_kind = cfg_kind_type'(phase % CFG_KINDS);
         case (cfg_kind)
            CFG_DEFAULT: begin
               carrier_pick   = CSR_DATA_W'(CARRIER_RESET);
               deviation_pick = CSR_DATA_W'(DEVIATION_RESET);
            end
            CFG_IN_RANGE: begin
               carrier_pick   = CSR_DATA_W'($urandom_range(250000000, 1));
               deviation_pick = CSR_DATA_W'($urandom_range(1000000, 1));
            end
            // low carriers push many samples into saturation or below zero
            CFG_LOW_CARRIER: begin
               carrier_pick   = CSR_DATA_W'($urandom_range(1200000, 1));
               deviation_pick = CSR_DATA_W'($urandom_range(1000000, 1));
            end
            CFG_TOP: begin
               carrier_pick   = 28'd250000000;
               deviation_pick = 28'd1000000;
            end
            CFG_BOTTOM: begin
               carrier_pick   = 28'd1;
               deviation_pick = 28'd1;
            end
            default: begin
               // any bit pattern; upper deviation data bits must be dropped
               carrier_pick   = CSR_DATA_W'($urandom);
               deviation_pick = CSR_DATA_W'($urandom);
            end
         endcase
         write_reg(CSR_CARRIER, carrier_pick);
         write_reg(CSR_DEVIATION, deviation_pick);

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // stall the receiver so the block fills and raises full
            if (phase == PRESSURE_PHASE && n == 5) hold_requests++;
            // stop offering until every expected beat has come back
            if (phase == PAUSE_PHASE && n == PHASE_ITEMS / 2) begin
               push <= 1'b0;
               do @(posedge clock); while (expected_divisors.size() != 0);
            end
            case ($urandom_range(15))
               0:       pcm = 16'sh8000;
               1:       pcm = 16'sh7FFF;
               2:       pcm = 16'sh0000;
               3:       pcm = 16'shFFFF;
               default: pcm = SAMPLE_W'($urandom);
            endcase
            offer_sample(pcm, predict_divisor(pcm));
         end
      end

      // Drop push, wait out every expectation, then watch for stray beats.
      push <= 1'b0;
      while (expected_divisors.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);

      $display("run: %0d samples sent, %0d result beats checked, %0d saturated",
               samples_sent, beats_checked, saturated_seen);
      $display("run: %0d register writes over %0d random phases, %0d mismatches",
               reg_writes, PHASES, errors);
      if (errors == 0) begin
         $display("[fm_sample_to_clock_divisor] OK");
      end else begin
         $display("[fm_sample_to_clock_divisor] ERROR");
      end
      $finish;
   end

endmodule
